FILE: rtl/core/assert_macros.svh
// Assertion macros for the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside of reset.
`define TMR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define TMR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/core/tmr_pkg.sv
// Types, constants and orientation mapping for the trackball motion core.
package tmr_pkg;

  localparam int unsigned SCALE_UNIT = 16;
  localparam int unsigned CNT_W      = 8;
  localparam int unsigned GAIN_W     = 8;
  localparam int unsigned MOVE_W     = 17;
  localparam int unsigned DIFF_W     = 18;
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 40;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned BTN_BIT    = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_ORIENT      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_UP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_DOWN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_LEFT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_RIGHT = 3'd4;

  typedef enum logic [1:0] {
    ORIENT_0   = 2'd0,
    ORIENT_90  = 2'd1,
    ORIENT_180 = 2'd2,
    ORIENT_270 = 2'd3
  } orient_t;

  typedef struct packed {
    orient_t             orient;
    logic [GAIN_W-1:0]   gain_up;
    logic [GAIN_W-1:0]   gain_down;
    logic [GAIN_W-1:0]   gain_left;
    logic [GAIN_W-1:0]   gain_right;
  } cfg_t;

  typedef struct packed {
    logic [CNT_W-1:0] left;
    logic [CNT_W-1:0] right;
    logic [CNT_W-1:0] up;
    logic [CNT_W-1:0] down;
  } count_t;

  typedef struct packed {
    logic [CNT_W-1:0]  cnt_a;
    logic [GAIN_W-1:0] gain_a;
    logic [CNT_W-1:0]  cnt_b;
    logic [GAIN_W-1:0] gain_b;
    logic              neg;
  } axis_op_t;

  typedef struct packed {
    axis_op_t x;
    axis_op_t y;
  } axes_t;

  function automatic axes_t map_axes(cfg_t cfg, count_t cnt);
    axes_t m;
    unique case (cfg.orient)
      ORIENT_0: begin
        m.x = '{cnt.right, cfg.gain_right, cnt.left, cfg.gain_left, 1'b0};
        m.y = '{cnt.up, cfg.gain_up, cnt.down, cfg.gain_down, 1'b1};
      end
      ORIENT_90: begin
        m.x = '{cnt.up, cfg.gain_right, cnt.down, cfg.gain_left, 1'b0};
        m.y = '{cnt.right, cfg.gain_down, cnt.left, cfg.gain_up, 1'b0};
      end
      ORIENT_180: begin
        m.x = '{cnt.right, cfg.gain_left, cnt.left, cfg.gain_right, 1'b1};
        m.y = '{cnt.up, cfg.gain_down, cnt.down, cfg.gain_up, 1'b0};
      end
      ORIENT_270: begin
        m.x = '{cnt.up, cfg.gain_left, cnt.down, cfg.gain_right, 1'b1};
        m.y = '{cnt.right, cfg.gain_up, cnt.left, cfg.gain_down, 1'b1};
      end
      default: begin
        m.x = '0;
        m.y = '0;
      end
    endcase
    return m;
  endfunction

endpackage

FILE: rtl/core/tmr_cfg.sv
// Configuration register file: orientation and per-direction gains.
module tmr_cfg
  import tmr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_ORIENT:      cfg_nxt.orient     = orient_t'(cfg_wdata[1:0]);
        CFG_SCALE_UP:    cfg_nxt.gain_up    = cfg_wdata[GAIN_W-1:0];
        CFG_SCALE_DOWN:  cfg_nxt.gain_down  = cfg_wdata[GAIN_W-1:0];
        CFG_SCALE_LEFT:  cfg_nxt.gain_left  = cfg_wdata[GAIN_W-1:0];
        CFG_SCALE_RIGHT: cfg_nxt.gain_right = cfg_wdata[GAIN_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.orient     <= ORIENT_270;
      cfg_r.gain_up    <= GAIN_W'(SCALE_UNIT);
      cfg_r.gain_down  <= GAIN_W'(SCALE_UNIT);
      cfg_r.gain_left  <= GAIN_W'(SCALE_UNIT);
      cfg_r.gain_right <= GAIN_W'(SCALE_UNIT);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/core/tmr_axis.sv
// One axis: two scaled counts, difference, sign and division by the scale unit.
module tmr_axis
  import tmr_pkg::*;
(
  input  axis_op_t                  op,
  output logic signed [MOVE_W-1:0]  move
);

  localparam logic signed [DIFF_W-1:0] SCALE_DIV = DIFF_W'(SCALE_UNIT);

  logic        [CNT_W+GAIN_W-1:0] prod_a;
  logic        [CNT_W+GAIN_W-1:0] prod_b;
  logic signed [DIFF_W-1:0]       diff;
  logic signed [DIFF_W-1:0]       signed_diff;
  logic signed [DIFF_W-1:0]       quot;

  assign prod_a      = op.cnt_a * op.gain_a;
  assign prod_b      = op.cnt_b * op.gain_b;
  assign diff        = $signed({2'b00, prod_a}) - $signed({2'b00, prod_b});
  assign signed_diff = op.neg ? -diff : diff;
  // truncate toward zero
  assign quot        = signed_diff / SCALE_DIV;
  assign move        = quot[MOVE_W-1:0];

endmodule

FILE: rtl/core/trackball_motion_to_relative_core.sv
// Top level: poll register, axis mapping and scaling, button tracking, result register.
//
//  channel | port group            | direction | contents
//  --------+-----------------------+-----------+-------------------------------------
//  input   | in_tvalid/tready/...  | in        | one sensor poll per word
//  result  | out_tvalid/tready/... | out       | X/Y move and button event per word
//  config  | cfg_we/index/wdata    | in        | orientation and four gains
//
//  An accepted poll passes through the poll register and then the result register.
//  A new word is accepted every cycle while the result side keeps up.
//  Polls with a clear motion flag are accepted and produce no result word.
//  A stalled result holds the poll register; in_tready drops only when both are full.
//  Reset is synchronous; it empties both registers and restores config defaults.
`include "assert_macros.svh"

module trackball_motion_to_relative_core
  import tmr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // count_left, count_right, count_up, count_down, button_byte
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // motion_flag
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // move_x, move_y, button_changed, button_down, zero fill
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t cfg;

  logic   s1_vld_r;
  logic   s1_vld_nxt;
  count_t cnt_r;
  logic   btn_r;

  logic                       out_vld_r;
  logic                       out_vld_nxt;
  logic signed [MOVE_W-1:0]   move_x_r;
  logic signed [MOVE_W-1:0]   move_y_r;
  logic                       chg_r;
  logic                       down_r;
  logic                       prev_btn_r;

  logic                       in_go;
  logic                       out_free;
  logic                       s1_go;
  axes_t                      axes;
  logic signed [MOVE_W-1:0]   move_x;
  logic signed [MOVE_W-1:0]   move_y;

  tmr_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  assign out_free  = !out_vld_r || out_tready;
  assign s1_go     = s1_vld_r && out_free;
  assign in_tready = !s1_vld_r || out_free;
  assign in_go     = in_tvalid && in_tready;

  // drop polls without motion at the door
  assign s1_vld_nxt  = in_go ? in_tuser : (s1_vld_r && !s1_go);
  assign out_vld_nxt = s1_go || (out_vld_r && !out_tready);

  assign axes = map_axes(cfg, cnt_r);

  tmr_axis u_axis_x (
    .op   (axes.x),
    .move (move_x)
  );

  tmr_axis u_axis_y (
    .op   (axes.y),
    .move (move_y)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
      prev_btn_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (s1_go) begin
        prev_btn_r <= btn_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_go) begin
      cnt_r.left  <= in_tdata[7:0];
      cnt_r.right <= in_tdata[15:8];
      cnt_r.up    <= in_tdata[23:16];
      cnt_r.down  <= in_tdata[31:24];
      btn_r       <= in_tdata[32+BTN_BIT];
    end
    if (s1_go) begin
      move_x_r <= move_x;
      move_y_r <= move_y;
      chg_r    <= btn_r ^ prev_btn_r;
      down_r   <= btn_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {4'b0000, down_r, chg_r, move_y_r, move_x_r};

  `TMR_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_tvalid, "result valid after reset")
  `TMR_ASSERT(a_flag_fills, (in_go && in_tuser) |=> s1_vld_r, "flagged poll lost")
  `TMR_ASSERT(a_btn_track, s1_go |=> (prev_btn_r == out_tdata[2*MOVE_W+1]),
              "button state out of step with result")

endmodule
